### hw/rtl/scp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine polynomial unit package
// Shared widths, fixed-point constants and the job type passed from the
// front end through the queue to the back end.
// ----------------------------------------------------------------------------
package scp_pkg;

  // Reduced angle in [0, 2pi), Q.24, and kernel argument in [0, pi/2].
  localparam int RED_W = 27;
  localparam int X_W   = 25;

  // Kernel words: u = x*x in Q.30, h = cos(x/2) in Q.30 (at most one).
  localparam int U_W       = 32;
  localparam int H_W       = 31;
  localparam int Q30_FRAC  = 30;
  localparam int U_SHIFT   = 18;
  localparam int OUT_SHIFT = 14;

  // Result format, Q1.16.
  localparam int OUT_W  = 18;
  localparam int BIAS_W = 18;

  localparam logic [H_W-1:0]    Q30_ONE = 31'd1073741824;
  localparam logic [BIAS_W-1:0] ONE_Q16 = 18'd65536;
  localparam logic [BIAS_W-1:0] TWO_Q16 = 18'd131072;

  localparam logic [RED_W-1:0] HALF_PI_Q24       = 27'd26353589;
  localparam logic [RED_W-1:0] PI_Q24            = 27'd52707179;
  localparam logic [RED_W-1:0] THREE_HALF_PI_Q24 = 27'd79060768;
  localparam logic [RED_W-1:0] TWO_PI_Q24        = 27'd105414357;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic           neg_c;
    logic           neg_s;
    logic [X_W-1:0] xc;
    logic [X_W-1:0] xs;
  } job_t;

endpackage

### hw/rtl/scp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine polynomial unit channels
// Valid/ready stream interfaces for the angle input and the result output.
// ----------------------------------------------------------------------------
interface scp_angle_if #(
  parameter int ANGLE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

interface scp_result_if ();
  import scp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] cosine;
  logic signed [OUT_W-1:0] sine;

  modport source (output valid, output cosine, output sine, input ready);
  modport sink (input valid, input cosine, input sine, output ready);
endinterface

### hw/rtl/sine_cosine_polynomial_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine polynomial unit
// Cosine and sine of a signed Q.24 angle in radians, as Q1.16 values.
//
//   Channel    Dir  Beat contents
//   angle_ch   in   angle  (ANGLE_WIDTH bits, signed, radians Q.24)
//   result_ch  out  cosine, sine (18 bits each, signed Q1.16)
//
// One beat is accepted per cycle and one result leaves per cycle while result_ch
// takes results. The front end's depth grows with ANGLE_WIDTH, set by the modulo
// two pi unit; the queue and the back end follow it.
// Reset clears all valid flags and the queue pointers; no clearing pass.
// Back-pressure on result_ch stalls the back end; the queue lets the
// front end keep accepting beats until it fills.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial_unit #(
  parameter int ANGLE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  scp_angle_if.sink    angle_ch,
  scp_result_if.source result_ch
);
  import scp_pkg::*;

  logic front_valid;
  logic front_ready;
  job_t front_job;
  logic back_valid;
  logic back_ready;
  job_t back_job;

  scp_front #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .angle_valid(angle_ch.valid),
    .angle_ready(angle_ch.ready),
    .angle      (angle_ch.angle),
    .job_valid  (front_valid),
    .job_ready  (front_ready),
    .job        (front_job)
  );

  scp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(front_valid),
    .wr_ready(front_ready),
    .wr_job  (front_job),
    .rd_valid(back_valid),
    .rd_ready(back_ready),
    .rd_job  (back_job)
  );

  scp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(back_valid),
    .job_ready(back_ready),
    .job      (back_job),
    .res_valid(result_ch.valid),
    .res_ready(result_ch.ready),
    .cosine   (result_ch.cosine),
    .sine     (result_ch.sine)
  );

endmodule

### hw/rtl/scp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine front end
// Folds the angle's sign, reduces the magnitude modulo two pi with one
// compare-subtract per stage and picks the quadrant's kernel arguments.
// ----------------------------------------------------------------------------
module scp_front #(
  parameter int ANGLE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   angle_valid,
  output logic                   angle_ready,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output logic                   job_valid,
  input  logic                   job_ready,
  output scp_pkg::job_t          job
);
  import scp_pkg::*;

  localparam int STEPS = (ANGLE_WIDTH > 26) ? ANGLE_WIDTH - 26 : 1;
  localparam int F_LAT = STEPS + 3;
  localparam int CMP_W = (ANGLE_WIDTH > RED_W) ? ANGLE_WIDTH : RED_W;

  logic [F_LAT-1:0]       v;
  logic                   adv;
  logic [ANGLE_WIDTH-1:0] raw;
  logic [F_LAT-2:1]       neg_sr;
  logic [ANGLE_WIDTH-1:0] red [STEPS+1];
  logic [RED_W-1:0]       a;
  job_t                   job_next;

  function automatic logic [ANGLE_WIDTH-1:0] red_step(input logic [ANGLE_WIDTH-1:0] r,
                                                      input int k);
    logic [CMP_W-1:0] lim;
    logic [CMP_W-1:0] rx;
    lim = CMP_W'(TWO_PI_Q24) << k;
    rx  = CMP_W'(r);
    if (rx >= lim) begin
      return ANGLE_WIDTH'(rx - lim);
    end
    return r;
  endfunction

  assign adv         = !v[F_LAT-1] || job_ready;
  assign angle_ready = adv;
  assign job_valid   = v[F_LAT-1];
  assign a           = RED_W'(red[STEPS]);

  always_comb begin
    job_next = '0;
    if (a > PI_Q24) begin
      if (a > THREE_HALF_PI_Q24) begin
        job_next.xc    = X_W'(TWO_PI_Q24 - a);
        job_next.neg_c = 1'b0;
        job_next.xs    = X_W'(a - THREE_HALF_PI_Q24);
        job_next.neg_s = 1'b1;
      end else begin
        job_next.xc    = X_W'(a - PI_Q24);
        job_next.neg_c = 1'b1;
        job_next.xs    = X_W'(THREE_HALF_PI_Q24 - a);
        job_next.neg_s = 1'b1;
      end
    end else if (a > HALF_PI_Q24) begin
      job_next.xc    = X_W'(PI_Q24 - a);
      job_next.neg_c = 1'b1;
      job_next.xs    = X_W'(a - HALF_PI_Q24);
      job_next.neg_s = 1'b0;
    end else begin
      job_next.xc    = X_W'(a);
      job_next.neg_c = 1'b0;
      job_next.xs    = X_W'(HALF_PI_Q24 - a);
      job_next.neg_s = 1'b0;
    end
    job_next.neg_s = job_next.neg_s ^ neg_sr[F_LAT-2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[F_LAT-2:0], angle_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      raw    <= angle;
      neg_sr <= {neg_sr[F_LAT-3:1], raw[ANGLE_WIDTH-1]};
      red[0] <= raw[ANGLE_WIDTH-1] ? -raw : raw;
      for (int i = 0; i < STEPS; i++) begin
        red[i+1] <= red_step(red[i], STEPS - 1 - i);
      end
      job <= job_next;
    end
  end

endmodule

### hw/rtl/scp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine job queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module scp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  scp_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_ready,
  output scp_pkg::job_t rd_job
);
  import scp_pkg::*;

  job_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic            push;
  logic            pop;

  assign wr_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

### hw/rtl/scp_hstep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine Horner step
// Computes h' = 1 - round(u*h / D) in Q.30 over four stages, where D is an
// odd constant times a power of two; the odd part is divided by a
// reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
module scp_hstep #(
  parameter int DIV_SHIFT = 5,
  parameter int DIV_ODD   = 7
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [scp_pkg::U_W-1:0] u,
  input  logic [scp_pkg::H_W-1:0] h,
  output logic [scp_pkg::U_W-1:0] u_pass,
  output logic [scp_pkg::H_W-1:0] h_res
);
  import scp_pkg::*;

  localparam int P_W = U_W + H_W;
  localparam int M_W = U_W - DIV_SHIFT;
  localparam int R_W = M_W + 1;
  localparam logic [R_W-1:0] RECIP    = R_W'((64'd1 << M_W) / DIV_ODD);
  localparam logic [U_W:0]   HALF_DIV = (U_W+1)'((DIV_ODD << DIV_SHIFT) / 2);
  localparam logic [P_W-1:0] P_RND    = P_W'(1) << (Q30_FRAC - 1);

  logic [P_W-1:0]     prod;
  logic [P_W-1:0]     prod_rnd;
  logic [U_W:0]       num;
  logic [M_W-1:0]     m;
  logic [M_W-1:0]     m3;
  logic [M_W+R_W-1:0] qprod;
  logic [M_W-1:0]     q0;
  logic [M_W-1:0]     rem;
  logic [M_W-1:0]     q;
  logic [U_W-1:0]     u1;
  logic [U_W-1:0]     u2;
  logic [U_W-1:0]     u3;

  assign prod_rnd = prod + P_RND;
  assign num      = (U_W+1)'(prod_rnd >> Q30_FRAC) + HALF_DIV;
  assign q0       = M_W'(qprod >> M_W);
  assign rem      = m3 - M_W'(q0 * DIV_ODD);
  assign q        = q0 + M_W'(rem >= M_W'(DIV_ODD));

  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= u * h;
      u1     <= u;
      m      <= M_W'(num >> DIV_SHIFT);
      u2     <= u1;
      qprod  <= m * RECIP;
      m3     <= m;
      u3     <= u2;
      h_res  <= Q30_ONE - H_W'(q);
      u_pass <= u3;
    end
  end

endmodule

### hw/rtl/scp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine back end
// Two kernel lanes, one per output: square the argument, run four Horner
// steps for cos(x/2), form 2h^2 - 1, round to Q1.16 and apply the sign.
// ----------------------------------------------------------------------------
module scp_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           job_valid,
  output logic                           job_ready,
  input  scp_pkg::job_t                  job,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic signed [scp_pkg::OUT_W-1:0] cosine,
  output logic signed [scp_pkg::OUT_W-1:0] sine
);
  import scp_pkg::*;

  localparam int N_STEP = 4;
  localparam int LAT    = 2 + 4 * N_STEP + 4;
  localparam int STEP_SHIFT [N_STEP] = '{5, 3, 4, 3};
  localparam int STEP_ODD   [N_STEP] = '{7, 15, 3, 1};

  logic [LAT-1:0]          v;
  logic                    en;
  logic [1:0]              neg_sr [LAT-1];
  logic [X_W-1:0]          x_in [2];
  logic signed [OUT_W-1:0] res [2];

  assign en        = !v[LAT-1] || res_ready;
  assign job_ready = en;
  assign res_valid = v[LAT-1];
  assign x_in[0]   = job.xc;
  assign x_in[1]   = job.xs;
  assign cosine    = res[0];
  assign sine      = res[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAT-2:0], job_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_sr[0] <= {job.neg_s, job.neg_c};
      for (int k = 1; k < LAT - 1; k++) begin
        neg_sr[k] <= neg_sr[k-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [2*X_W-1:0]        xx;
    logic [U_W-1:0]          u;
    logic [U_W-1:0]          u_c [N_STEP+1];
    logic [H_W-1:0]          h_c [N_STEP+1];
    logic [2*H_W-1:0]        hh;
    logic [H_W-1:0]          sqr;
    logic [BIAS_W-1:0]       biased;
    logic [OUT_W:0]          diff;
    logic signed [OUT_W-1:0] c;

    assign u_c[0] = u;
    assign h_c[0] = Q30_ONE;

    for (genvar j = 0; j < N_STEP; j++) begin : g_step
      scp_hstep #(
        .DIV_SHIFT(STEP_SHIFT[j]),
        .DIV_ODD  (STEP_ODD[j])
      ) u_hstep (
        .clk   (clk),
        .en    (en),
        .u     (u_c[j]),
        .h     (h_c[j]),
        .u_pass(u_c[j+1]),
        .h_res (h_c[j+1])
      );
    end

    assign diff = {1'b0, biased} - (OUT_W+1)'(ONE_Q16);
    assign c    = (biased > TWO_Q16) ? OUT_W'(ONE_Q16) : OUT_W'(diff);

    always_ff @(posedge clk) begin
      if (en) begin
        xx     <= x_in[l] * x_in[l];
        u      <= U_W'((xx + ((2*X_W)'(1) << (U_SHIFT - 1))) >> U_SHIFT);
        hh     <= h_c[N_STEP] * h_c[N_STEP];
        sqr    <= H_W'((hh + ((2*H_W)'(1) << (Q30_FRAC - 1))) >> Q30_FRAC);
        biased <= BIAS_W'(({sqr, 1'b0} + ((H_W+1)'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT);
        res[l] <= neg_sr[LAT-2][l] ? -c : c;
      end
    end
  end

endmodule

### test/sine_cosine_polynomial_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine polynomial unit testbench
// Drives signed Q7.24 angles into the unit and checks every cosine/sine pair
// against an in-bench fixed-point predictor. Directed angles cover the
// quadrant boundaries, multiples of two pi and the range extremes. Random
// angles follow, with random idle cycles on both channels, one long result
// stall and one drain pause.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial_unit_tb;
  import scp_pkg::*;

  localparam int AW          = 32;
  localparam int RANDOM_BEATS = 1900;
  localparam int DRAIN_CYCLES = 48;
  localparam int STALL_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 200000;

  class trig_scoreboard;
    typedef struct {
      logic signed [AW-1:0]    angle;
      logic signed [OUT_W-1:0] cosine;
      logic signed [OUT_W-1:0] sine;
    } trig_pair_t;

    trig_pair_t pending[$];
    int         errors;

    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic signed [OUT_W-1:0] quarter_cos(longint unsigned x);
      longint unsigned one;
      longint unsigned u;
      longint unsigned h;
      longint unsigned sq;
      longint unsigned biased;
      longint          r;
      one = longint'(Q30_ONE);
      u = (x * x + (64'd1 << 17)) >> 18;
      h = one - (u + 64'd112) / 64'd224;
      h = one - (q30_mul(u, h) + 64'd60) / 64'd120;
      h = one - (q30_mul(u, h) + 64'd24) / 64'd48;
      h = one - (q30_mul(u, h) + 64'd4) / 64'd8;
      sq = q30_mul(h, h);
      biased = (64'd2 * sq + (64'd1 << 13)) >> 14;
      r = longint'(biased) - 65536;
      if (r > 65536) r = 65536;
      if (r < -65536) r = -65536;
      return r[OUT_W-1:0];
    endfunction

    function void note_angle(logic signed [AW-1:0] ang);
      longint unsigned mag;
      trig_pair_t      e;
      e.angle = ang;
      mag = ang[AW-1] ? longint'(-longint'(ang)) : longint'(ang);
      mag = mag % longint'(TWO_PI_Q24);
      if (mag > PI_Q24) begin
        if (mag > THREE_HALF_PI_Q24) begin
          e.cosine = quarter_cos(longint'(TWO_PI_Q24) - mag);
          e.sine   = -quarter_cos(mag - longint'(THREE_HALF_PI_Q24));
        end else begin
          e.cosine = -quarter_cos(mag - longint'(PI_Q24));
          e.sine   = -quarter_cos(longint'(THREE_HALF_PI_Q24) - mag);
        end
      end else begin
        if (mag > HALF_PI_Q24) begin
          e.cosine = -quarter_cos(longint'(PI_Q24) - mag);
          e.sine   = quarter_cos(mag - longint'(HALF_PI_Q24));
        end else begin
          e.cosine = quarter_cos(mag);
          e.sine   = quarter_cos(longint'(HALF_PI_Q24) - mag);
        end
      end
      if (ang[AW-1]) e.sine = -e.sine;
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [OUT_W-1:0] cosine, logic signed [OUT_W-1:0] sine);
      trig_pair_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got cosine %0d sine %0d",
                 $time, cosine, sine);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (cosine !== e.cosine) begin
        $display("%0t: cosine mismatch for angle %0d: expected %0d, got %0d",
                 $time, e.angle, e.cosine, cosine);
        errors++;
      end
      if (sine !== e.sine) begin
        $display("%0t: sine mismatch for angle %0d: expected %0d, got %0d",
                 $time, e.angle, e.sine, sine);
        errors++;
      end
    endfunction

    function bit idle();
      return pending.size() == 0;
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count;

  scp_angle_if #(.ANGLE_WIDTH(AW)) angle_ch ();
  scp_result_if result_ch ();

  sine_cosine_polynomial_unit #(
    .ANGLE_WIDTH(AW)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .angle_ch (angle_ch),
    .result_ch(result_ch)
  );

  trig_scoreboard sc = new();

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sine_cosine_polynomial_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic send_angle(input logic signed [AW-1:0] ang, input int gap, input bit drain);
    if (drain) begin
      @(negedge clk);
      angle_ch.valid <= 1'b0;
      while (!sc.idle()) @(posedge clk);
    end
    if (gap > 0) begin
      @(negedge clk);
      angle_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    angle_ch.valid <= 1'b1;
    angle_ch.angle <= ang;
    do @(posedge clk); while (!angle_ch.ready);
    sc.note_angle(ang);
  endtask

  function automatic logic signed [AW-1:0] random_angle();
    longint base;
    longint v;
    int     kind;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      v = longint'($signed($urandom()));
    end else if (kind <= 5) begin
      v = longint'($urandom_range(0, 2 * TWO_PI_Q24)) - longint'(TWO_PI_Q24);
    end else if (kind <= 8) begin
      case ($urandom_range(0, 4))
        0: base = 0;
        1: base = longint'(HALF_PI_Q24);
        2: base = longint'(PI_Q24);
        3: base = longint'(THREE_HALF_PI_Q24);
        default: base = longint'(TWO_PI_Q24);
      endcase
      v = longint'($urandom_range(0, 19)) * longint'(TWO_PI_Q24) + base
          + longint'($urandom_range(0, 64)) - 32;
      if (v < 0) v = 0;
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      v = longint'($urandom_range(0, 4095));
      if ($urandom_range(0, 1)) v = -v;
    end
    return v[AW-1:0];
  endfunction

  initial begin
    logic signed [AW-1:0] directed[$];
    int                   gap;
    bit                   burst;
    rst = 1'b1;
    angle_ch.valid = 1'b0;
    angle_ch.angle = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff, 32'sh80000000,
                 AW'(HALF_PI_Q24), AW'(HALF_PI_Q24) + 1, AW'(PI_Q24) - 1, AW'(PI_Q24),
                 AW'(PI_Q24) + 1, AW'(THREE_HALF_PI_Q24), AW'(THREE_HALF_PI_Q24) + 1,
                 AW'(TWO_PI_Q24) - 1, AW'(TWO_PI_Q24), AW'(TWO_PI_Q24) + 1,
                 -AW'(HALF_PI_Q24), -AW'(PI_Q24), -AW'(THREE_HALF_PI_Q24),
                 -AW'(TWO_PI_Q24), 4 * AW'(TWO_PI_Q24) + AW'(HALF_PI_Q24),
                 32'sd16777216, -32'sd16777216, 32'sh55555555, 32'shaaaaaaaa};
    foreach (directed[i]) send_angle(directed[i], $urandom_range(0, 3), 1'b0);

    burst = 1'b0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(0, 2) == 0);
      gap = burst ? 0 : $urandom_range(0, 3);
      send_angle(random_angle(), gap, n == 1200);
    end

    @(negedge clk);
    angle_ch.valid <= 1'b0;
    while (!sc.idle()) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sc.errors == 0 && sc.idle()) begin
      $display("sine_cosine_polynomial_unit_tb: done, clean");
    end else begin
      $display("sine_cosine_polynomial_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    int gap;
    int results_seen;
    bit burst;
    result_ch.ready = 1'b0;
    results_seen = 0;
    burst = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results_seen % 64 == 0) burst = ($urandom_range(0, 2) == 0);
      gap = burst ? 0 : $urandom_range(0, 3);
      if (results_seen == 500) gap = STALL_CYCLES;
      if (gap > 0) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      sc.check_result(result_ch.cosine, result_ch.sine);
      results_seen++;
    end
  end

endmodule

### filelist.f
hw/rtl/scp_pkg.sv
hw/rtl/scp_if.sv
hw/rtl/scp_front.sv
hw/rtl/scp_queue.sv
hw/rtl/scp_hstep.sv
hw/rtl/scp_back.sv
hw/rtl/sine_cosine_polynomial_unit.sv
test/sine_cosine_polynomial_unit_tb.sv
